/* rtl/mck_pkg.sv */
// Shared types, constants and the character table of the Morse keyer.
// Used by every module of the block; depends on nothing.
package mck_pkg;

   localparam int unsigned MAX_ELEMENTS_DEFAULT = 5;
   localparam int unsigned PAT_W = 5;                // table holds up to five elements
   localparam int unsigned LEN_W = 3;
   localparam int unsigned TABLE_DEPTH = 36;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W = 16;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_DOT_MS         = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DASH_MS        = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ELEMENT_GAP_MS = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LETTER_GAP_MS  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_DOT_PERIOD_MS  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_DASH_PERIOD_MS = 3'd5;

   // register reset values
   localparam logic [15:0] DOT_MS_RESET         = 16'd200;
   localparam logic [15:0] DASH_MS_RESET        = 16'd600;
   localparam logic [15:0] ELEMENT_GAP_MS_RESET = 16'd400;
   localparam logic [15:0] LETTER_GAP_MS_RESET  = 16'd1500;
   localparam logic [7:0]  DOT_PERIOD_MS_RESET  = 8'd1;
   localparam logic [7:0]  DASH_PERIOD_MS_RESET = 8'd150;

   // character ranges
   localparam logic [7:0] CHAR_UPPER_FIRST = 8'd65;
   localparam logic [7:0] CHAR_UPPER_LAST  = 8'd90;
   localparam logic [7:0] CHAR_DIGIT_FIRST = 8'd48;
   localparam logic [7:0] CHAR_DIGIT_LAST  = 8'd57;
   localparam logic [7:0] DIGIT_OFFSET     = 8'd22;

   typedef enum logic [1:0] {
      KIND_DOT  = 2'd0,
      KIND_DASH = 2'd1,
      KIND_EGAP = 2'd2,
      KIND_LGAP = 2'd3
   } segment_kind_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_message;
   } req_type;

   typedef struct packed {
      segment_kind_type segment_kind;
      logic [15:0]      duration_ms;
      logic [7:0]       tone_period_ms;
      logic             last_of_char;
   } rsp_type;

   typedef struct packed {
      logic [15:0] dot_ms;
      logic [15:0] dash_ms;
      logic [15:0] element_gap_ms;
      logic [15:0] letter_gap_ms;
      logic [7:0]  dot_period_ms;
      logic [7:0]  dash_period_ms;
   } csr_type;

   // element count and pattern; bit 0 is sent first, 1 is a dash
   typedef struct packed {
      logic [LEN_W-1:0] len;
      logic [PAT_W-1:0] pat;
   } morse_entry_type;

   typedef struct packed {
      logic             mapped;
      logic [LEN_W-1:0] len;
      logic [PAT_W-1:0] pat;
   } morse_lookup_type;

   // A-Z at 0..25, digits 0-9 at 26..35
   localparam morse_entry_type MORSE_TABLE [TABLE_DEPTH] = '{
      8'b010_00010, 8'b100_00001, 8'b100_00101, 8'b011_00001, 8'b001_00000,
      8'b100_00100, 8'b011_00011, 8'b100_00000, 8'b010_00000, 8'b100_01110,
      8'b011_00101, 8'b100_00010, 8'b010_00011, 8'b010_00001, 8'b011_00111,
      8'b100_00110, 8'b100_01011, 8'b011_00010, 8'b011_00000, 8'b001_00001,
      8'b011_00100, 8'b100_01000, 8'b011_00110, 8'b100_01001, 8'b100_01101,
      8'b100_00011,
      8'b101_11111, 8'b101_11110, 8'b101_11100, 8'b101_11000, 8'b101_10000,
      8'b101_00000, 8'b101_00001, 8'b101_00011, 8'b101_00111, 8'b101_01111
   };

   function automatic morse_lookup_type morse_lookup(input logic [7:0] ch);
      morse_lookup_type res;
      logic [7:0]       diff;
      res  = '0;
      diff = 8'd0;
      if (ch >= CHAR_UPPER_FIRST && ch <= CHAR_UPPER_LAST) begin
         diff = ch - CHAR_UPPER_FIRST;
         res.mapped = 1'b1;
      end else if (ch >= CHAR_DIGIT_FIRST && ch <= CHAR_DIGIT_LAST) begin
         diff = ch - DIGIT_OFFSET;
         res.mapped = 1'b1;
      end
      if (res.mapped) begin
         res.len = MORSE_TABLE[diff[5:0]].len;
         res.pat = MORSE_TABLE[diff[5:0]].pat;
      end
      return res;
   endfunction

endpackage

/* rtl/mck_csr_regs.sv */
// Timing and tone register file of the Morse keyer.
// Depends on mck_pkg for register indexes, reset values and the csr_type bundle.
module mck_csr_regs (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [mck_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mck_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output mck_pkg::csr_type                 regs
);

   mck_pkg::csr_type regs_ff;
   mck_pkg::csr_type regs_in;

   assign csr_ready = 1'b1;
   assign regs      = regs_ff;

   always_comb begin
      regs_in = regs_ff;
      if (csr_valid) begin
         case (csr_index)
            mck_pkg::CSR_DOT_MS:         regs_in.dot_ms         = csr_wdata;
            mck_pkg::CSR_DASH_MS:        regs_in.dash_ms        = csr_wdata;
            mck_pkg::CSR_ELEMENT_GAP_MS: regs_in.element_gap_ms = csr_wdata;
            mck_pkg::CSR_LETTER_GAP_MS:  regs_in.letter_gap_ms  = csr_wdata;
            mck_pkg::CSR_DOT_PERIOD_MS:  regs_in.dot_period_ms  = csr_wdata[7:0];
            mck_pkg::CSR_DASH_PERIOD_MS: regs_in.dash_period_ms = csr_wdata[7:0];
            default: ; // drop writes beyond the register list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.dot_ms         <= mck_pkg::DOT_MS_RESET;
         regs_ff.dash_ms        <= mck_pkg::DASH_MS_RESET;
         regs_ff.element_gap_ms <= mck_pkg::ELEMENT_GAP_MS_RESET;
         regs_ff.letter_gap_ms  <= mck_pkg::LETTER_GAP_MS_RESET;
         regs_ff.dot_period_ms  <= mck_pkg::DOT_PERIOD_MS_RESET;
         regs_ff.dash_period_ms <= mck_pkg::DASH_PERIOD_MS_RESET;
      end else begin
         regs_ff <= regs_in;
      end
   end

endmodule

/* rtl/mck_segment_shifter.sv */
// Element shift register and segment sequencer: one segment per cycle unless the output stalls.
// Depends on mck_pkg for the segment and register bundle types.
module mck_segment_shifter #(
   parameter int unsigned MaxElements = mck_pkg::MAX_ELEMENTS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load_valid,
   output logic                          load_ready,
   input  logic [mck_pkg::LEN_W-1:0]     load_len,
   input  logic [mck_pkg::PAT_W-1:0]     load_pat,
   input  mck_pkg::csr_type              regs,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output mck_pkg::rsp_type              rsp_data
);

   localparam int unsigned CntW = $clog2(MaxElements + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_TONE,
      ST_GAP,
      ST_LAST
   } state_type;

   state_type            state_ff, state_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   mck_pkg::rsp_type     rsp_data_ff, rsp_data_in;
   logic [MaxElements-1:0] pat_ff, pat_in;
   logic [CntW-1:0]      cnt_ff, cnt_in;
   logic [CntW-1:0]      len_ext;
   logic [CntW-1:0]      len_clip;
   logic                 out_free;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign load_ready = (state_ff == ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   assign len_ext  = CntW'(load_len);
   assign len_clip = (len_ext > CntW'(MaxElements)) ? CntW'(MaxElements) : len_ext;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      pat_in       = pat_ff;
      cnt_in       = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (load_valid) begin
               pat_in   = MaxElements'(load_pat);
               cnt_in   = len_clip;
               state_in = (len_clip == '0) ? ST_LAST : ST_TONE;
            end
         end
         ST_TONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (pat_ff[0]) begin
                  rsp_data_in.segment_kind   = mck_pkg::KIND_DASH;
                  rsp_data_in.duration_ms    = regs.dash_ms;
                  rsp_data_in.tone_period_ms = regs.dash_period_ms;
               end else begin
                  rsp_data_in.segment_kind   = mck_pkg::KIND_DOT;
                  rsp_data_in.duration_ms    = regs.dot_ms;
                  rsp_data_in.tone_period_ms = regs.dot_period_ms;
               end
               rsp_data_in.last_of_char = 1'b0;
               state_in = ST_GAP;
            end
         end
         ST_GAP: begin
            if (out_free) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.segment_kind    = mck_pkg::KIND_EGAP;
               rsp_data_in.duration_ms     = regs.element_gap_ms;
               rsp_data_in.tone_period_ms  = 8'd0;
               rsp_data_in.last_of_char    = 1'b0;
               // advance to the next element
               pat_in   = pat_ff >> 1;
               cnt_in   = cnt_ff - 1'b1;
               state_in = (cnt_ff == CntW'(1)) ? ST_LAST : ST_TONE;
            end
         end
         ST_LAST: begin
            if (out_free) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.segment_kind    = mck_pkg::KIND_LGAP;
               rsp_data_in.duration_ms     = regs.letter_gap_ms;
               rsp_data_in.tone_period_ms  = 8'd0;
               rsp_data_in.last_of_char    = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      pat_ff      <= pat_in;
      cnt_ff      <= cnt_in;
   end

endmodule

/* rtl/morse_character_keyer_unit.sv */
// Morse keyer top level: character lookup, message suppression, register file
// and segment sequencer. Depends on mck_pkg, mck_csr_regs, mck_segment_shifter.
// A taken request is loaded into the sequencer state and shift register; the first
// segment is then registered in the response register once the output is free.
// Segments follow at one per cycle while the output is not stalled; the next
// request is taken once the letter gap has been issued. Reset is synchronous:
// registers return to their default timings and suppression is cleared.
module morse_character_keyer_unit #(
   parameter int unsigned MaxElements = mck_pkg::MAX_ELEMENTS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  mck_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output mck_pkg::rsp_type                 rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [mck_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mck_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   mck_pkg::csr_type         regs;
   mck_pkg::morse_lookup_type lookup;
   logic                     suppressed_ff, suppressed_in;
   logic                     req_accept;
   logic                     start;

   assign lookup     = mck_pkg::morse_lookup(req_data.char_code);
   assign req_accept = req_valid && req_ready;
   assign start      = req_accept && !suppressed_ff && lookup.mapped;

   // an unmapped character silences the rest of the message
   always_comb begin
      suppressed_in = suppressed_ff;
      if (req_accept) begin
         if (req_data.end_of_message) begin
            suppressed_in = 1'b0;
         end else if (!lookup.mapped) begin
            suppressed_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         suppressed_ff <= 1'b0;
      end else begin
         suppressed_ff <= suppressed_in;
      end
   end

   mck_csr_regs u_csr_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .regs      (regs)
   );

   mck_segment_shifter #(
      .MaxElements (MaxElements)
   ) u_segment_shifter (
      .clock      (clock),
      .reset      (reset),
      .load_valid (start),
      .load_ready (req_ready),
      .load_len   (lookup.len),
      .load_pat   (lookup.pat),
      .regs       (regs),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

/* tb/morse_character_keyer_unit_tb.sv */
// Self-checking bench for morse_character_keyer_unit: drives characters and timing
// registers, predicts every tone and gap segment, and checks each response in order.
// Depends on mck_pkg and the keyer RTL.
module morse_character_keyer_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned ELEMENT_LIMIT = mck_pkg::MAX_ELEMENTS_DEFAULT;
   localparam int unsigned SETTLE_CYCLES = 20;
   localparam int unsigned MAX_WAIT = 17;
   localparam int unsigned CHARS_PER_PHASE = 78;
   localparam int unsigned PHASES = 5;
   // indexes that map to no register
   localparam logic [mck_pkg::CSR_INDEX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [mck_pkg::CSR_INDEX_W-1:0] CSR_SPARE_HI = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   mck_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   mck_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [mck_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [mck_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // A-Z then 0-9
   string morse_codes [36] = '{
      ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
      "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
      "..-", "...-", ".--", "-..-", "-.--", "--..",
      "-----", ".----", "..---", "...--", "....-", ".....",
      "-....", "--...", "---..", "----."
   };

   mck_pkg::csr_type keyer_timing;
   bit message_muted = 1'b0;
   mck_pkg::rsp_type segments_due [$];
   mck_pkg::req_type pending_chars [$];
   int unsigned chars_queued = 0;
   int unsigned chars_taken = 0;
   int unsigned n_errors = 0;
   bit req_calm = 1'b0;
   bit rsp_calm = 1'b0;
   int unsigned req_hold = 0;
   int unsigned rsp_hold = 0;

   morse_character_keyer_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic bit char_slot(input logic [7:0] ch, output int unsigned slot);
      slot = 0;
      if (ch >= "A" && ch <= "Z") begin
         slot = ch - "A";
         return 1'b1;
      end
      if (ch >= "0" && ch <= "9") begin
         slot = ch - "0" + 26;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic int unsigned pick_wait(input bit calm);
      return calm ? 0 : $urandom_range(0, MAX_WAIT);
   endfunction

   // expected segments of one accepted character
   function automatic void key_character(input mck_pkg::req_type item);
      int unsigned slot;
      int unsigned pos;
      string pat;
      mck_pkg::rsp_type seg;
      if (!message_muted) begin
         if (!char_slot(item.char_code, slot)) begin
            message_muted = 1'b1;
         end else begin
            pat = morse_codes[slot];
            for (pos = 0; pos < ELEMENT_LIMIT && pos < pat.len(); pos++) begin
               if (pat.getc(pos) == ".") begin
                  seg.segment_kind   = mck_pkg::KIND_DOT;
                  seg.duration_ms    = keyer_timing.dot_ms;
                  seg.tone_period_ms = keyer_timing.dot_period_ms;
               end else begin
                  seg.segment_kind   = mck_pkg::KIND_DASH;
                  seg.duration_ms    = keyer_timing.dash_ms;
                  seg.tone_period_ms = keyer_timing.dash_period_ms;
               end
               seg.last_of_char = 1'b0;
               segments_due.push_back(seg);
               seg.segment_kind   = mck_pkg::KIND_EGAP;
               seg.duration_ms    = keyer_timing.element_gap_ms;
               seg.tone_period_ms = 8'd0;
               segments_due.push_back(seg);
            end
            seg.segment_kind   = mck_pkg::KIND_LGAP;
            seg.duration_ms    = keyer_timing.letter_gap_ms;
            seg.tone_period_ms = 8'd0;
            seg.last_of_char   = 1'b1;
            segments_due.push_back(seg);
         end
      end
      if (item.end_of_message) message_muted = 1'b0;
   endfunction

   function automatic void check_segment(input mck_pkg::rsp_type got);
      mck_pkg::rsp_type want;
      if (segments_due.size() == 0) begin
         $display("%0t: segment with none expected: expected nothing, actual %h", $time, got);
         n_errors++;
         return;
      end
      want = segments_due.pop_front();
      if (got.segment_kind !== want.segment_kind) begin
         $display("%0t: segment_kind expected %0d actual %0d", $time,
                  want.segment_kind, got.segment_kind);
         n_errors++;
      end
      if (got.duration_ms !== want.duration_ms) begin
         $display("%0t: duration_ms expected %0d actual %0d", $time,
                  want.duration_ms, got.duration_ms);
         n_errors++;
      end
      if (got.tone_period_ms !== want.tone_period_ms) begin
         $display("%0t: tone_period_ms expected %0d actual %0d", $time,
                  want.tone_period_ms, got.tone_period_ms);
         n_errors++;
      end
      if (got.last_of_char !== want.last_of_char) begin
         $display("%0t: last_of_char expected %0d actual %0d", $time,
                  want.last_of_char, got.last_of_char);
         n_errors++;
      end
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_hold = 0;
      end else begin
         if (req_valid && req_ready) begin
            key_character(req_data);
            chars_taken++;
            req_hold = pick_wait(req_calm);
         end
         if (!req_valid || req_ready) begin
            if (req_hold > 0) begin
               req_hold--;
               req_valid <= 1'b0;
            end else if (pending_chars.size() != 0) begin
               req_data  <= pending_chars.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor with random back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_segment(rsp_data);
            rsp_hold = pick_wait(rsp_calm);
         end else if (rsp_hold > 0) begin
            rsp_hold--;
         end
         rsp_ready <= (rsp_hold == 0);
      end
   end

   task automatic offer_character(input logic [7:0] ch, input logic eom);
      mck_pkg::req_type item;
      item.char_code      = ch;
      item.end_of_message = eom;
      pending_chars.push_back(item);
      chars_queued++;
   endtask

   // hold until every request is taken and every segment has come back
   task automatic drain();
      while (chars_taken != chars_queued || segments_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [mck_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         mck_pkg::CSR_DOT_MS:         keyer_timing.dot_ms = value;
         mck_pkg::CSR_DASH_MS:        keyer_timing.dash_ms = value;
         mck_pkg::CSR_ELEMENT_GAP_MS: keyer_timing.element_gap_ms = value;
         mck_pkg::CSR_LETTER_GAP_MS:  keyer_timing.letter_gap_ms = value;
         mck_pkg::CSR_DOT_PERIOD_MS:  keyer_timing.dot_period_ms = value[7:0];
         mck_pkg::CSR_DASH_PERIOD_MS: keyer_timing.dash_period_ms = value[7:0];
         default: ;
      endcase
   endtask

   task automatic program_timing(input logic [15:0] dot, input logic [15:0] dash,
                                 input logic [15:0] egap, input logic [15:0] lgap,
                                 input logic [15:0] dot_per, input logic [15:0] dash_per);
      write_csr(mck_pkg::CSR_DOT_MS, dot);
      write_csr(CSR_SPARE_LO, 16'($urandom_range(0, 65535)));
      write_csr(mck_pkg::CSR_DASH_MS, dash);
      write_csr(mck_pkg::CSR_ELEMENT_GAP_MS, egap);
      write_csr(mck_pkg::CSR_LETTER_GAP_MS, lgap);
      write_csr(mck_pkg::CSR_DOT_PERIOD_MS, dot_per);
      write_csr(mck_pkg::CSR_DASH_PERIOD_MS, dash_per);
      write_csr(CSR_SPARE_HI, 16'($urandom_range(0, 65535)));
      csr_valid <= 1'b0;
   endtask

   initial begin
      #5_000_000;
      $display("morse_character_keyer_unit test failed");
      $finish;
   end

   initial begin
      int unsigned offered_count;
      int unsigned roll;
      logic [7:0] ch;
      keyer_timing.dot_ms         = mck_pkg::DOT_MS_RESET;
      keyer_timing.dash_ms        = mck_pkg::DASH_MS_RESET;
      keyer_timing.element_gap_ms = mck_pkg::ELEMENT_GAP_MS_RESET;
      keyer_timing.letter_gap_ms  = mck_pkg::LETTER_GAP_MS_RESET;
      keyer_timing.dot_period_ms  = mck_pkg::DOT_PERIOD_MS_RESET;
      keyer_timing.dash_period_ms = mck_pkg::DASH_PERIOD_MS_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single dot, single dash, table ends, five-element digits
      offer_character("E", 1'b0);
      offer_character("T", 1'b0);
      offer_character("A", 1'b0);
      offer_character("Z", 1'b0);
      offer_character("5", 1'b0);
      offer_character("0", 1'b0);
      offer_character("9", 1'b0);
      offer_character("Q", 1'b1);
      // unmapped mutes the message until its end
      offer_character("@", 1'b0);
      offer_character("B", 1'b0);
      offer_character("[", 1'b1);
      offer_character("C", 1'b0);
      // unmapped carrying end of message leaves nothing muted
      offer_character("/", 1'b1);
      offer_character("1", 1'b0);
      offer_character(":", 1'b0);
      offer_character(8'hFF, 1'b0);
      offer_character("Y", 1'b1);
      offer_character("8", 1'b0);
      offer_character(8'h00, 1'b1);
      offer_character("a", 1'b1);
      offer_character("M", 1'b1);
      offer_character("7", 1'b0);
      drain();

      for (int phase = 0; phase < PHASES; phase++) begin
         req_calm = ($urandom_range(0, 2) == 0);
         rsp_calm = ($urandom_range(0, 2) == 0);
         case (phase)
            1: program_timing(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
            2: program_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            3: program_timing(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                              16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                              16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
            4: program_timing(16'($urandom_range(1, 10)), 16'($urandom_range(1, 30)),
                              16'($urandom_range(1, 10)), 16'($urandom_range(1, 70)),
                              16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
            default: ;
         endcase
         offered_count = 0;
         while (offered_count < CHARS_PER_PHASE) begin
            roll = $urandom_range(0, 99);
            if (roll < 55) ch = 8'("A" + $urandom_range(0, 25));
            else if (roll < 82) ch = 8'("0" + $urandom_range(0, 9));
            else ch = 8'($urandom_range(0, 255));
            offer_character(ch, ($urandom_range(0, 99) < 18));
            offered_count++;
         end
         drain();
      end

      if (segments_due.size() != 0) begin
         $display("%0t: segments left over: expected 0, actual %0d", $time, segments_due.size());
         n_errors++;
      end
      if (n_errors == 0) begin
         $display("morse_character_keyer_unit test passed");
      end else begin
         $display("morse_character_keyer_unit test failed");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/mck_pkg.sv
rtl/mck_csr_regs.sv
rtl/mck_segment_shifter.sv
rtl/morse_character_keyer_unit.sv
tb/morse_character_keyer_unit_tb.sv
